/* src/stx_etx_frame_receiver_top_defines.svh */
// Assertion macros shared by the STX/ETX frame receiver RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef STX_ETX_FRAME_RECEIVER_TOP_DEFINES_SVH
`define STX_ETX_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sefr_pkg.sv */
// Shared types, codes and defaults for the STX/ETX frame receiver.
// No dependencies; imported by every module of the block.
package sefr_pkg;

	// Field widths (fixed by the stream format)
	localparam int KindW  = 2;
	localparam int ByteW  = 8;
	localparam int EventW = 3;
	localparam int PosW   = 6;
	localparam int LenW   = 7;
	localparam int AckW   = 2;
	localparam int CfgAddrW = 2;

	localparam int MAX_FRAME_LEN_DEF = 64;
	localparam int ACK_COUNT_DONE    = 3;

	// Input kinds
	localparam logic [KindW-1:0] KIND_BYTE  = 2'd0;
	localparam logic [KindW-1:0] KIND_ARM   = 2'd1;
	localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;

	// Result events
	localparam logic [EventW-1:0] EV_IGNORED     = 3'd0;
	localparam logic [EventW-1:0] EV_OPENED      = 3'd1;
	localparam logic [EventW-1:0] EV_STORED      = 3'd2;
	localparam logic [EventW-1:0] EV_DONE        = 3'd3;
	localparam logic [EventW-1:0] EV_ACK_COUNTED = 3'd4;
	localparam logic [EventW-1:0] EV_ACK_DONE    = 3'd5;
	localparam logic [EventW-1:0] EV_OVERFLOW    = 3'd6;

	// Acknowledge status
	localparam logic [AckW-1:0] ACK_IDLE = 2'd0;
	localparam logic [AckW-1:0] ACK_WAIT = 2'd1;
	localparam logic [AckW-1:0] ACK_RCVD = 2'd2;

	// Register indexes
	localparam logic [CfgAddrW-1:0] CFG_START = 2'd0;
	localparam logic [CfgAddrW-1:0] CFG_END   = 2'd1;
	localparam logic [CfgAddrW-1:0] CFG_ACK   = 2'd2;

	// Register reset values
	localparam logic [ByteW-1:0] START_DEF = 8'h02;
	localparam logic [ByteW-1:0] END_DEF   = 8'h03;
	localparam logic [ByteW-1:0] ACK_DEF   = 8'h06;

	typedef struct packed {
		logic [ByteW-1:0] start_byte;
		logic [ByteW-1:0] end_byte;
		logic [ByteW-1:0] ack_byte;
	} cfg_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [AckW-1:0] ack_state;
		logic            in_frame;
	} flags_t;

	typedef struct packed {
		logic [EventW-1:0] event_res;
		logic [ByteW-1:0]  data_byte;
		logic [PosW-1:0]   position;
		logic [LenW-1:0]   frame_length;
		logic [AckW-1:0]   ack_status;
	} result_t;

endpackage

/* src/sefr_cfg_regs.sv */
// Configuration registers (start, end and acknowledge byte values).
// Depends on sefr_pkg.
module sefr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sefr_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [sefr_pkg::ByteW-1:0]    cfg_wdata,
	output sefr_pkg::cfg_t                cfg
);
	import sefr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_DEF;
			cfg_q.end_byte   <= END_DEF;
			cfg_q.ack_byte   <= ACK_DEF;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_START: cfg_q.start_byte <= cfg_wdata;
				CFG_END:   cfg_q.end_byte   <= cfg_wdata;
				CFG_ACK:   cfg_q.ack_byte   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/sefr_step.sv */
// Per-item deframer decision: next state and result for one item.
// Depends on sefr_pkg.
module sefr_step #(
	parameter  int MAX_FRAME_LEN = sefr_pkg::MAX_FRAME_LEN_DEF,
	localparam int FillW         = $clog2(MAX_FRAME_LEN + 1)
) (
	input  sefr_pkg::cfg_t    cfg,
	input  sefr_pkg::item_t   item,
	input  sefr_pkg::flags_t  flags_cur,
	input  logic [FillW-1:0]  fill_cur,
	output sefr_pkg::flags_t  flags_nxt,
	output logic [FillW-1:0]  fill_nxt,
	output sefr_pkg::result_t res
);
	import sefr_pkg::*;

	logic full;
	logic ack_last;

	assign full     = fill_cur >= FillW'(MAX_FRAME_LEN);
	// the third acknowledge byte is the one stored at index 2
	assign ack_last = fill_cur == FillW'(ACK_COUNT_DONE - 1);

	always_comb begin
		flags_nxt = flags_cur;
		fill_nxt  = fill_cur;
		res       = '0;
		res.event_res = EV_IGNORED;
		case (item.kind)
			KIND_ARM:   flags_nxt.ack_state = ACK_WAIT;
			KIND_CLEAR: flags_nxt.ack_state = ACK_IDLE;
			KIND_BYTE: begin
				if (flags_cur.ack_state == ACK_WAIT) begin
					if (item.rx_byte != cfg.ack_byte) begin
						res.event_res = EV_IGNORED;
					end else if (full) begin
						res.event_res = EV_OVERFLOW;
					end else begin
						res.data_byte = item.rx_byte;
						res.position  = PosW'(fill_cur);
						if (ack_last) begin
							fill_nxt            = '0;
							flags_nxt.in_frame  = 1'b0;
							flags_nxt.ack_state = ACK_RCVD;
							res.event_res       = EV_ACK_DONE;
							res.frame_length    = LenW'(ACK_COUNT_DONE);
						end else begin
							fill_nxt      = fill_cur + FillW'(1);
							res.event_res = EV_ACK_COUNTED;
						end
					end
				end else if (!flags_cur.in_frame) begin
					if (item.rx_byte == cfg.start_byte) begin
						flags_nxt.in_frame = 1'b1;
						res.event_res      = EV_OPENED;
					end
				end else if (item.rx_byte == cfg.end_byte) begin
					fill_nxt           = '0;
					flags_nxt.in_frame = 1'b0;
					res.event_res      = EV_DONE;
					res.frame_length   = LenW'(fill_cur);
				end else if (full) begin
					res.event_res = EV_OVERFLOW;
				end else begin
					fill_nxt      = fill_cur + FillW'(1);
					res.event_res = EV_STORED;
					res.data_byte = item.rx_byte;
					res.position  = PosW'(fill_cur);
				end
			end
			default: ;
		endcase
		res.ack_status = flags_nxt.ack_state;
	end

endmodule

/* src/stx_etx_frame_receiver_top.sv */
// Top level of the STX/ETX frame receiver: input register, step logic, result register.
// Depends on sefr_pkg, sefr_cfg_regs, sefr_step and the assertion macro header.
//
// Usage:
//  - s_axis carries one item per transfer: tuser = kind (0 byte, 1 arm ack wait,
//    2 clear ack status), tdata = received byte.
//  - m_axis returns exactly one result per input transfer, in order:
//    tuser = event code, tdata = data byte, position, frame length, ack status.
//  - cfg_we/cfg_addr/cfg_wdata write start, end and ack byte values (index 0..2);
//    writes to index 3 are dropped. Write only while the block is idle.
//  - Path: an accepted item is held in the input register, then its result is
//    written into the result register, from which it transfers on m_axis.
//  - Throughput: one item per cycle while m_axis_tready is high; the state update (ack status,
//    frame flag, fill count) is registered as the item moves into the result register.
//  - Stall: when m_axis_tready is low the result register holds, one more item
//    waits in the input register, then s_axis_tready drops. Nothing is lost.
//  - Reset: arst_n clears both stages, the frame state and fill count, and
//    restores the default byte values 0x02, 0x03 and 0x06.
module stx_etx_frame_receiver_top #(
	parameter int MAX_FRAME_LEN = sefr_pkg::MAX_FRAME_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	input  logic [1:0]                    s_axis_tuser,  // [1:0] kind
	// result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] data_byte, [13:8] position, [20:14] frame_length,
	// [22:21] ack_status, [23] zero
	output logic [23:0]                   m_axis_tdata,
	output logic [2:0]                    m_axis_tuser,  // [2:0] event_res
	// configuration
	input  logic                          cfg_we,
	input  logic [sefr_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [sefr_pkg::ByteW-1:0]    cfg_wdata
);
	import sefr_pkg::*;
	`include "stx_etx_frame_receiver_top_defines.svh"

	localparam int FillW = $clog2(MAX_FRAME_LEN + 1);

	cfg_t             cfg;
	logic             valid_s1;
	item_t            item_s1;
	logic             valid_s2;
	result_t          res_s2;
	flags_t           flags_q;
	logic [FillW-1:0] fill_q;
	flags_t           flags_nxt;
	logic [FillW-1:0] fill_nxt;
	result_t          res_nxt;
	logic             advance;
	logic             in_xfer;

	// an item moves to the result register when that register is free or drains
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	sefr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sefr_step #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_step (
		.cfg       (cfg),
		.item      (item_s1),
		.flags_cur (flags_q),
		.fill_cur  (fill_q),
		.flags_nxt (flags_nxt),
		.fill_nxt  (fill_nxt),
		.res       (res_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.kind    <= s_axis_tuser;
			item_s1.rx_byte <= s_axis_tdata;
		end
	end

	// deframer state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q.ack_state <= ACK_IDLE;
			flags_q.in_frame  <= 1'b0;
			fill_q            <= '0;
		end else if (advance) begin
			flags_q <= flags_nxt;
			fill_q  <= fill_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.event_res;
	assign m_axis_tdata  = {1'b0, res_s2.ack_status, res_s2.frame_length,
		res_s2.position, res_s2.data_byte};

	// fill count never runs past the buffer size
	`SEFR_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1,
		fill_q <= FillW'(MAX_FRAME_LEN), "fill count above MAX_FRAME_LEN")
	// ack status only takes its three defined values
	`SEFR_ASSERT_NOW(a_ack_code, clk, arst_n, 1'b1,
		flags_q.ack_state != 2'd3, "ack state holds an undefined code")
	// a completed acknowledge reports received status
	`SEFR_ASSERT_NOW(a_ack_done_status, clk, arst_n,
		valid_s2 && res_s2.event_res == EV_ACK_DONE,
		res_s2.ack_status == ACK_RCVD, "ack done without received status")
	// closing a frame or an acknowledge leaves the fill count at zero
	`SEFR_ASSERT_NEXT(a_close_clears, clk, arst_n,
		advance && (res_nxt.event_res == EV_DONE || res_nxt.event_res == EV_ACK_DONE),
		fill_q == '0 && !flags_q.in_frame, "frame close did not clear state")
	// a waiting item stays put while the result register is stalled
	`SEFR_ASSERT_NEXT(a_s1_hold, clk, arst_n,
		valid_s1 && valid_s2 && !m_axis_tready,
		valid_s1 && $stable(item_s1), "stalled input item changed")

endmodule
